FILE: src/ipmbfc_pkg.sv
// shared types and constants for the ipmb frame checker
`timescale 1ns / 1ps

package ipmbfc_pkg;

	localparam int MaxFrameDefault = 64;

	localparam logic [7:0] MIN_FRAME = 8'd6;
	localparam logic [7:0] HDR_BYTES = 8'd3;
	localparam logic [7:0] SEQ_BYTE  = 8'd4;
	localparam logic [7:0] CC_BYTE   = 8'd6;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_HDR   = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_CC    = 3'd4;
	localparam logic [2:0] ST_SEQ   = 3'd5;
	localparam logic [2:0] ST_LONG  = 3'd6;

	localparam logic REG_EXPECTED_SEQ = 1'b0;

	localparam int OUT_BITS  = 17;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] cmpl_code;
		logic [5:0] received_seq;
	} verdict_t;

endpackage

FILE: src/ipmbfc_cfg.sv
// apb register block holding the expected sequence number
`timescale 1ns / 1ps

module ipmbfc_cfg
	import ipmbfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [5:0]  expected_seq
);

	logic [5:0] expected_seq_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_EXPECTED_SEQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= 6'd0;
		end else if (wr_en) begin
			expected_seq_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_EXPECTED_SEQ) begin
			prdata = {26'd0, expected_seq_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign expected_seq = expected_seq_q;

endmodule

FILE: src/ipmbfc_accum.sv
// per-frame running state and the verdict logic
`timescale 1ns / 1ps

module ipmbfc_accum
	import ipmbfc_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       proc,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	input  logic [5:0] expected_seq,
	output verdict_t   verdict
);

	logic [7:0] byte_count_q;
	logic [7:0] header_sum_q;
	logic [7:0] body_sum_q;
	logic [5:0] seq_field_q;
	logic [7:0] cc_field_q;
	logic       overlength_q;

	logic [7:0] count_n;
	logic [7:0] header_n;
	logic [7:0] body_n;
	logic [5:0] seq_n;
	logic [7:0] cc_n;
	logic       overlength_n;

	always_comb begin
		overlength_n = overlength_q || (byte_count_q >= 8'(MAX_FRAME));
		header_n     = header_sum_q;
		body_n       = body_sum_q;
		if (byte_count_q < HDR_BYTES) begin
			header_n = header_sum_q + rx_byte;
		end else begin
			body_n = body_sum_q + rx_byte;
		end
		seq_n   = (byte_count_q == SEQ_BYTE) ? rx_byte[7:2] : seq_field_q;
		cc_n    = (byte_count_q == CC_BYTE) ? rx_byte : cc_field_q;
		// count saturates, sums keep running
		count_n = (byte_count_q != COUNT_MAX) ? byte_count_q + 8'd1 : byte_count_q;
	end

	always_comb begin
		verdict.cmpl_code    = cc_n;
		verdict.received_seq = seq_n;
		// frame length is index + 1, so short means index below 5
		if (overlength_n) begin
			verdict.status = ST_LONG;
		end else if (byte_count_q < MIN_FRAME - 8'd1) begin
			verdict.status = ST_SHORT;
		end else if (header_n != 8'd0) begin
			verdict.status = ST_HDR;
		end else if (body_n != 8'd0) begin
			verdict.status = ST_DATA;
		end else if (cc_n != 8'd0) begin
			verdict.status = ST_CC;
		end else if (seq_n != expected_seq) begin
			verdict.status = ST_SEQ;
		end else begin
			verdict.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 8'd0;
			header_sum_q <= 8'd0;
			body_sum_q   <= 8'd0;
			seq_field_q  <= 6'd0;
			cc_field_q   <= 8'd0;
			overlength_q <= 1'b0;
		end else if (proc) begin
			if (last_byte) begin
				byte_count_q <= 8'd0;
				header_sum_q <= 8'd0;
				body_sum_q   <= 8'd0;
				seq_field_q  <= 6'd0;
				cc_field_q   <= 8'd0;
				overlength_q <= 1'b0;
			end else begin
				byte_count_q <= count_n;
				header_sum_q <= header_n;
				body_sum_q   <= body_n;
				seq_field_q  <= seq_n;
				cc_field_q   <= cc_n;
				overlength_q <= overlength_n;
			end
		end
	end

endmodule

FILE: src/ipmb_frame_checker_top.sv
// ipmb response frame checker: byte stream in, one verdict item per frame out
// bytes are checked from the input register; each verdict is held in the output register
// throughput: one byte per cycle unless a last byte meets a stalled verdict;
// the input register keeps taking bytes while a verdict waits in the output register;
// only a last byte meeting a stalled verdict holds the input
// reset: asynchronous, clears frame state, expected_seq and both valid flags
`timescale 1ns / 1ps

module ipmb_frame_checker_top
	import ipmbfc_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,  // [7:0] rx_byte
	input  logic                     s_tlast,  // last_byte
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_BYTES*8-1:0]   m_tdata,  // [2:0] status, [10:3] cmpl_code,
	                                           // [16:11] received_seq, rest zero
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       last_s1;
	logic       m_tvalid_q;
	verdict_t   verdict_q;
	verdict_t   verdict;
	logic [5:0] expected_seq;
	logic       adv;

	ipmbfc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.expected_seq (expected_seq)
	);

	// a non-last byte never needs the output register
	assign adv      = valid_s1 && !(last_s1 && m_tvalid_q && !m_tready);
	assign s_tready = !valid_s1 || adv;

	ipmbfc_accum #(
		.MAX_FRAME (MAX_FRAME)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.proc         (adv),
		.rx_byte      (rx_byte_s1),
		.last_byte    (last_s1),
		.expected_seq (expected_seq),
		.verdict      (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
			last_s1    <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, verdict_q.received_seq,
		verdict_q.cmpl_code, verdict_q.status};

	// input only holds for a last byte blocked by a stalled verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && m_tvalid_q && !m_tready))
		else $error("input held without a pending verdict stall");

	// a processed last byte always yields a verdict next cycle
	a_verdict_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> m_tvalid)
		else $error("verdict lost after last byte");

	// status code 7 is never produced
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd7))
		else $error("undefined status code");

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the ipmb frame checker: byte stream in, verdicts checked
`timescale 1ns / 1ps

module testbench;
	import ipmbfc_pkg::*;

	localparam int FRAME_LIMIT = MaxFrameDefault;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] SEQ_ADDR = 3'(REG_EXPECTED_SEQ) << 2;

	typedef enum {FK_GOOD, FK_HDR_BAD, FK_BODY_BAD, FK_CC_BAD, FK_SEQ_BAD, FK_SHORT,
		FK_LONG, FK_NOISE} frame_kind_t;
	typedef enum {RM_ALWAYS, RM_RANDOM, RM_PATTERN} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;  // [7:0] rx_byte
	logic                 s_tlast = 1'b0;   // last_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_BYTES*8-1:0] m_tdata;        // [2:0] status, [10:3] cmpl_code,
	                                        // [16:11] received_seq
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = 3'd0;
	logic [31:0]          pwdata = 32'd0;
	logic [31:0]          prdata;
	logic                 pready;

	// frame state of the predictor
	logic [7:0] frm_count = 8'd0;
	logic [7:0] frm_hdr_sum = 8'd0;
	logic [7:0] frm_body_sum = 8'd0;
	logic [5:0] frm_seq = 6'd0;
	logic [7:0] frm_cc = 8'd0;
	logic       frm_long = 1'b0;
	logic [5:0] cfg_seq = 6'd0;

	verdict_t verdict_q [$];
	verdict_t got_v, want_v;

	int err_count = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int verdicts_seen = 0;
	int status_hits [0:7];
	int burst_left = 0;
	bit gaps_on = 1'b0;
	ready_mode_t ready_mode = RM_ALWAYS;
	int ready_phase = 0;
	logic holding = 1'b0;
	event hold_go;

	ipmb_frame_checker_top #(.MAX_FRAME(FRAME_LIMIT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		err_count++;
	endtask

	// one frame byte into the predictor; a last byte yields a verdict
	task automatic predict_byte(input logic [7:0] b, input logic last);
		verdict_t v;
		logic [8:0] len;
		len = {1'b0, frm_count} + 9'd1;
		if (frm_count >= FRAME_LIMIT)
			frm_long = 1'b1;
		if (frm_count < HDR_BYTES)
			frm_hdr_sum = frm_hdr_sum + b;
		else
			frm_body_sum = frm_body_sum + b;
		if (frm_count == SEQ_BYTE)
			frm_seq = b[7:2];
		if (frm_count == CC_BYTE)
			frm_cc = b;
		if (frm_count != COUNT_MAX)
			frm_count = frm_count + 8'd1;
		if (last) begin
			if (frm_long)
				v.status = ST_LONG;
			else if (len < {1'b0, MIN_FRAME})
				v.status = ST_SHORT;
			else if (frm_hdr_sum != 8'd0)
				v.status = ST_HDR;
			else if (frm_body_sum != 8'd0)
				v.status = ST_DATA;
			else if (frm_cc != 8'd0)
				v.status = ST_CC;
			else if (frm_seq != cfg_seq)
				v.status = ST_SEQ;
			else
				v.status = ST_OK;
			v.cmpl_code = frm_cc;
			v.received_seq = frm_seq;
			verdict_q.push_back(v);
			frm_count = 8'd0;
			frm_hdr_sum = 8'd0;
			frm_body_sum = 8'd0;
			frm_seq = 6'd0;
			frm_cc = 8'd0;
			frm_long = 1'b0;
		end
	endtask

	// verdicts are checked before the byte of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_v.status = m_tdata[2:0];
				got_v.cmpl_code = m_tdata[10:3];
				got_v.received_seq = m_tdata[16:11];
				verdicts_seen++;
				status_hits[got_v.status]++;
				if (verdict_q.size() == 0) begin
					report_mismatch("verdict with none pending, status", -1, got_v.status);
				end else begin
					want_v = verdict_q.pop_front();
					if (got_v.status != want_v.status)
						report_mismatch("status", want_v.status, got_v.status);
					if (got_v.cmpl_code != want_v.cmpl_code)
						report_mismatch("cmpl_code", want_v.cmpl_code,
							got_v.cmpl_code);
					if (got_v.received_seq != want_v.received_seq)
						report_mismatch("received_seq", want_v.received_seq,
							got_v.received_seq);
				end
			end
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
		end
	end

	always @(posedge clk) begin
		ready_phase <= ready_phase + 1;
		case (ready_mode)
			RM_ALWAYS: m_tready <= !holding;
			RM_RANDOM: m_tready <= !holding && ($urandom_range(0, 3) != 0);
			default: m_tready <= !holding && ((ready_phase % 11) > 3);
		endcase
	end

	// long receiver hold-off, counted here so the sender keeps running
	initial begin
		forever begin
			@(hold_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_expected_seq(input logic [5:0] seq);
		apb_write(SEQ_ADDR, {26'd0, seq});
		cfg_seq = seq;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
	endtask

	task automatic send_list(input logic [7:0] bytes [$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
		frames_sent++;
	endtask

	// valid checksums unless noise or short, then breaks what the kind asks for
	task automatic send_frame(input frame_kind_t kind, input int len);
		logic [7:0] fb [$];
		logic [7:0] acc;
		int fix;
		int k;
		fb = {};
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom));
		if (kind != FK_NOISE && kind != FK_SHORT && len >= MIN_FRAME) begin
			fb[2] = -(fb[0] + fb[1]);
			if (kind == FK_SEQ_BAD)
				fb[4] = {cfg_seq ^ 6'($urandom_range(1, 63)), fb[4][1:0]};
			else
				fb[4] = {cfg_seq, fb[4][1:0]};
			if (len > CC_BYTE)
				fb[6] = (kind == FK_CC_BAD) ? 8'($urandom_range(1, 255)) : 8'd0;
			// balancing byte must not be the sequence or completion byte
			fix = (len > 7) ? len - 1 : 5;
			fb[fix] = 8'd0;
			acc = 8'd0;
			for (int i = HDR_BYTES; i < len; i++)
				acc = acc + fb[i];
			fb[fix] = -acc;
			if (kind == FK_HDR_BAD) begin
				k = $urandom_range(0, 2);
				fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
			end
			if (kind == FK_BODY_BAD)
				fb[3] = fb[3] + 8'($urandom_range(1, 255));
		end
		send_list(fb);
	endtask

	task automatic wait_all_verdicts();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_frames(input int byte_goal);
		frame_kind_t kind;
		int start;
		int pick;
		int len;
		start = items_sent;
		while (items_sent - start < byte_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) kind = FK_GOOD;
			else if (pick < 63) kind = FK_HDR_BAD;
			else if (pick < 71) kind = FK_BODY_BAD;
			else if (pick < 78) kind = FK_CC_BAD;
			else if (pick < 85) kind = FK_SEQ_BAD;
			else if (pick < 91) kind = FK_SHORT;
			else if (pick < 94) kind = FK_LONG;
			else kind = FK_NOISE;
			case (kind)
				FK_SHORT: len = $urandom_range(1, 5);
				FK_LONG: len = $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 10);
				FK_NOISE: len = $urandom_range(1, 16);
				FK_CC_BAD: len = $urandom_range(7, 14);
				default: len = ($urandom_range(0, 19) == 0) ?
					$urandom_range(15, FRAME_LIMIT) : $urandom_range(6, 14);
			endcase
			send_frame(kind, len);
		end
	endtask

	// field extremes, missing sequence and completion bytes, completion error
	task automatic test_directed();
		gaps_on = 1'b0;
		ready_mode = RM_ALWAYS;
		send_list('{8'h00});
		send_list('{8'hFF});
		send_list('{8'hFF, 8'h01, 8'h00, 8'hFF});
		send_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
		send_list('{8'h01, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h80});
		send_list('{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'hFF});
		wait_all_verdicts();
	endtask

	// frame at the limit, one past it, and one that runs the counter into saturation
	task automatic test_long_frames();
		gaps_on = 1'b1;
		ready_mode = RM_RANDOM;
		send_frame(FK_GOOD, FRAME_LIMIT);
		send_frame(FK_GOOD, FRAME_LIMIT + 1);
		send_frame(FK_NOISE, 260);
		wait_all_verdicts();
	endtask

	task automatic test_config_phases();
		logic [5:0] seqs [5];
		seqs = '{6'd63, 6'($urandom), 6'd0, 6'($urandom), 6'd21};
		foreach (seqs[p]) begin
			set_expected_seq(seqs[p]);
			gaps_on = (p % 2) == 0;
			ready_mode = ready_mode_t'(p % 3);
			run_random_frames(20);
			// sender pauses until the block has emptied, then resumes
			wait_all_verdicts();
			run_random_frames(20);
			wait_all_verdicts();
		end
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		ready_mode = RM_ALWAYS;
		->hold_go;
		repeat (20) send_frame(FK_GOOD, 6);
		wait_all_verdicts();
	endtask

	initial begin
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_expected_seq(6'd0);
		test_directed();
		test_long_frames();
		test_config_phases();
		test_backpressure();
		$display("summary: %0d bytes in %0d frames, %0d verdicts checked, %0d mismatches",
			items_sent, frames_sent, verdicts_seen, err_count);
		$display("summary: ok %0d short %0d hdr %0d data %0d cc %0d seq %0d long %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6]);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
